// ===== rtl/core/tts_pkg.sv =====
package tts_pkg;

    // field widths
    localparam int RAW_W    = 16;
    localparam int SCALED_W = 15;
    localparam int MAG_W    = 14;
    localparam int BCD_W    = 20;

    // conversion constants: centi-degrees = floor(Scale * raw / 2^16) - Offset
    localparam logic [SCALED_W-1:0] TTS_SCALE  = 15'd17572;
    localparam logic [SCALED_W-1:0] TTS_OFFSET = 15'd4685;

    // fixed display codes
    localparam logic [7:0] SEG_BLANK  = 8'h00;
    localparam logic [2:0] SEG_MINUS  = 3'd4;
    localparam logic [2:0] SEG_PLUS   = 3'd0;
    localparam logic       SEG_DOT    = 1'b1;
    localparam logic [7:0] SEG_LETTER = 8'h9C;
    localparam logic [2:0] SEG_DEGREE = 3'd4;

    // bcd digit to segment byte
    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        logic [7:0] code;
        unique case (digit)
            4'd0:    code = 8'hFC;
            4'd1:    code = 8'h60;
            4'd2:    code = 8'hDB;
            4'd3:    code = 8'hF3;
            4'd4:    code = 8'h67;
            4'd5:    code = 8'hB7;
            4'd6:    code = 8'hBF;
            4'd7:    code = 8'hE0;
            4'd8:    code = 8'hFF;
            4'd9:    code = 8'hF7;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

// ===== rtl/core/tts_mul.sv =====
// bit-serial shift-add multiply by the scale constant, keeps the upper half only
module tts_mul (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_load,
    input  logic [tts_pkg::RAW_W-1:0]     i_raw,
    output logic                          o_done,
    output logic [tts_pkg::SCALED_W-1:0]  o_scaled
);

    logic [tts_pkg::SCALED_W-1:0] r_hi;
    logic [tts_pkg::RAW_W-1:0]    r_bits;
    logic [3:0]                   r_cnt;
    logic                         r_run;
    logic                         r_done;
    logic [tts_pkg::SCALED_W:0]   n_sum;

    // partial sum stays below twice the constant
    assign n_sum = {1'b0, r_hi} + (r_bits[0] ? {1'b0, tts_pkg::TTS_SCALE}
                                              : {(tts_pkg::SCALED_W+1){1'b0}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_hi   <= '0;
                r_bits <= i_raw;
                r_cnt  <= 4'd0;
                r_run  <= 1'b1;
            end else if (r_run) begin
                r_hi   <= n_sum[tts_pkg::SCALED_W:1];
                r_bits <= r_bits >> 1;
                r_cnt  <= r_cnt + 4'd1;
                if (r_cnt == 4'(tts_pkg::RAW_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done   = r_done;
    assign o_scaled = r_hi;

endmodule

// ===== rtl/core/tts_bcd.sv =====
// serial double dabble, one magnitude bit per cycle
module tts_bcd (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_load,
    input  logic [tts_pkg::MAG_W-1:0]  i_mag,
    output logic                       o_done,
    output logic [tts_pkg::BCD_W-1:0]  o_bcd
);

    localparam int Digits = tts_pkg::BCD_W / 4;

    logic [tts_pkg::MAG_W-1:0] r_bin;
    logic [tts_pkg::BCD_W-1:0] r_bcd;
    logic [3:0]                r_cnt;
    logic                      r_run;
    logic                      r_done;
    logic [tts_pkg::BCD_W-1:0] n_adj;

    // add three to any digit of five or more before the shift
    always_comb begin
        for (int d = 0; d < Digits; d++) begin
            if (r_bcd[d*4 +: 4] >= 4'd5) begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4] + 4'd3;
            end else begin
                n_adj[d*4 +: 4] = r_bcd[d*4 +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= 4'd0;
        end else begin
            r_done <= 1'b0;
            if (i_load) begin
                r_bin <= i_mag;
                r_bcd <= '0;
                r_cnt <= 4'd0;
                r_run <= 1'b1;
            end else if (r_run) begin
                r_bcd <= {n_adj[tts_pkg::BCD_W-2:0], r_bin[tts_pkg::MAG_W-1]};
                r_bin <= r_bin << 1;
                r_cnt <= r_cnt + 4'd1;
                if (r_cnt == 4'(tts_pkg::MAG_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_bcd  = r_bcd;

endmodule

// ===== rtl/core/temperature_to_segment_display.sv =====
// Converts one raw 16-bit sensor sample into the full segment image of its
// temperature, "-###.# degC". A sample is taken when start is high while busy
// is low; busy then stays high through the bit-serial scale multiply, the
// hand-over to the bcd stage and the serial binary to bcd conversion of the
// magnitude, and the result beat follows the hand-over of the bcd result to
// the output register. A new sample can be taken at the edge that ends the
// result beat. The result appears for exactly one cycle with o_strobe high and
// the receiver cannot stall it; the output ports then hold the last image.
// Leading zero digits are blank, the tenths digit is always shown.
module temperature_to_segment_display (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [tts_pkg::RAW_W-1:0]     i_raw_reading,
    output logic                          o_strobe,
    output logic [7:0]                    o_digit_one_segments,
    output logic [7:0]                    o_digit_two_segments,
    output logic [7:0]                    o_digit_three_segments,
    output logic [7:0]                    o_digit_four_segments,
    output logic [2:0]                    o_sign_byte,
    output logic                          o_dot_byte,
    output logic [7:0]                    o_unit_letter_byte,
    output logic [2:0]                    o_degree_byte
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_BCD
    } t_state;

    t_state r_state;
    logic   r_neg;
    logic   r_strobe;
    logic [7:0] r_seg1, r_seg2, r_seg3, r_seg4;

    logic                         mul_load;
    logic                         mul_done;
    logic [tts_pkg::SCALED_W-1:0] scaled;
    logic                         below;
    logic [tts_pkg::SCALED_W-1:0] diff;
    logic [tts_pkg::MAG_W-1:0]    mag;
    logic                         bcd_done;
    logic [tts_pkg::BCD_W-1:0]    bcd;
    logic [3:0]                   d4, d3, d2, d1;
    logic [7:0]                   n_seg1, n_seg2, n_seg3, n_seg4;

    // beat accepted only from idle
    assign mul_load = start && (r_state == S_IDLE);

    tts_mul u_mul (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (mul_load),
        .i_raw    (i_raw_reading),
        .o_done   (mul_done),
        .o_scaled (scaled)
    );

    // centi-degree magnitude and sign, one compare and subtract
    // the multiplier holds its product until the next load
    assign below = scaled < tts_pkg::TTS_OFFSET;
    assign diff  = below ? (tts_pkg::TTS_OFFSET - scaled) : (scaled - tts_pkg::TTS_OFFSET);
    assign mag   = diff[tts_pkg::MAG_W-1:0];

    tts_bcd u_bcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (mul_done),
        .i_mag   (mag),
        .o_done  (bcd_done),
        .o_bcd   (bcd)
    );

    // the lowest bcd digit is hundredths, dropped to give tenths
    assign d4 = bcd[19:16];
    assign d3 = bcd[15:12];
    assign d2 = bcd[11:8];
    assign d1 = bcd[7:4];

    // leading zero blanking, tenths always shown
    always_comb begin
        n_seg4 = tts_pkg::seg_code(d1);
        n_seg3 = ((d4 | d3 | d2) != 4'd0) ? tts_pkg::seg_code(d2) : tts_pkg::SEG_BLANK;
        n_seg2 = ((d4 | d3) != 4'd0)      ? tts_pkg::seg_code(d3) : tts_pkg::SEG_BLANK;
        n_seg1 = (d4 != 4'd0)             ? tts_pkg::seg_code(d4) : tts_pkg::SEG_BLANK;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (mul_done) begin
                        r_state <= S_BCD;
                    end
                end
                S_BCD: begin
                    if (bcd_done) begin
                        r_neg    <= below;
                        r_seg1   <= n_seg1;
                        r_seg2   <= n_seg2;
                        r_seg3   <= n_seg3;
                        r_seg4   <= n_seg4;
                        r_strobe <= 1'b1;
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign busy                   = (r_state != S_IDLE);
    assign o_strobe               = r_strobe;
    assign o_digit_one_segments   = r_seg1;
    assign o_digit_two_segments   = r_seg2;
    assign o_digit_three_segments = r_seg3;
    assign o_digit_four_segments  = r_seg4;
    assign o_sign_byte            = r_neg ? tts_pkg::SEG_MINUS : tts_pkg::SEG_PLUS;
    // fixed symbols of the image
    assign o_dot_byte             = tts_pkg::SEG_DOT;
    assign o_unit_letter_byte     = tts_pkg::SEG_LETTER;
    assign o_degree_byte          = tts_pkg::SEG_DEGREE;

endmodule

// ===== rtl/core/tts_checker.sv =====
module tts_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic       busy,
    input  logic       o_strobe,
    input  logic [7:0] o_digit_four_segments,
    input  logic [2:0] o_sign_byte
);

    // an accepted beat makes the block busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted beat did not raise busy");

    // result beat lasts one cycle
    a_strobe_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("result strobe longer than one cycle");

    // a result only ends a busy spell
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) && !busy))
        else $error("result beat without preceding work");

    // tenths digit is never blank and the sign byte is minus or nothing
    a_result_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_digit_four_segments != 8'h00)
                      && (o_sign_byte == 3'd0 || o_sign_byte == 3'd4)))
        else $error("malformed result image");

endmodule

bind temperature_to_segment_display tts_checker u_tts_checker (.*);
